@@ hdl/rrs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants for the range reference shift block
// Holds the field widths, the mode and register index codes, and the control
// word that the top level hands to each axis unit.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Fixed widths of the transaction fields.
  localparam int PORT_BITS  = 64;
  localparam int DELTA_BITS = 32;
  localparam int INDEX_BITS = 3;

  // Adjustment modes. The unused code makes no change.
  typedef enum logic [1:0] {
    MODE_SHIFT   = 2'd0,
    MODE_MOVE    = 2'd1,
    MODE_REORDER = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [INDEX_BITS-1:0] {
    CFG_MODE     = 3'd0,
    CFG_COL_LO   = 3'd1,
    CFG_COL_HI   = 3'd2,
    CFG_ROW_LO   = 3'd3,
    CFG_ROW_HI   = 3'd4,
    CFG_SHEET_LO = 3'd5,
    CFG_SHEET_HI = 3'd6
  } cfg_index_t;

  // Control word for one axis unit.
  typedef struct packed {
    logic en;     // move this axis
    logic clamp;  // insert/delete rule: clamp high overflow, skip bounds below start
  } axis_ctl_t;

endpackage

@@ hdl/range_reference_shift_top.sv @@
// ----------------------------------------------------------------------------
// range_reference_shift_top: 3-D reference range adjustment
// Adjusts one column/row/sheet reference range per transaction against a
// configured region, in insert/delete, move or no-change mode.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------
// command   | start, busy                | shift_*, ref_*_lo, ref_*_hi
// result    | done (one-cycle strobe)    | new_*_lo, new_*_hi, status
// config    | cfg_we                     | cfg_index, cfg_data
//
// A command transaction is taken at every edge where start is high and busy
// is low; busy is only high during reset, so a new command may come in every
// cycle. The command lands in the input register, one pass of logic through
// the three axis units follows, and the result register shows it with done
// at the next edge. Throughput is one transaction per cycle, set by the
// single register-to-register pass. The receiver cannot stall, so results
// are never held. Reset clears the pipeline valid bits, the mode and the
// region bounds (all bounds read as coordinate zero).
//
module range_reference_shift_top #(
  parameter int COORD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rrs_pkg::DELTA_BITS-1:0] shift_col,
  input  logic signed [rrs_pkg::DELTA_BITS-1:0] shift_row,
  input  logic signed [rrs_pkg::DELTA_BITS-1:0] shift_sheet,
  input  logic signed [rrs_pkg::PORT_BITS-1:0]  ref_col_lo,
  input  logic signed [rrs_pkg::PORT_BITS-1:0]  ref_row_lo,
  input  logic signed [rrs_pkg::PORT_BITS-1:0]  ref_sheet_lo,
  input  logic signed [rrs_pkg::PORT_BITS-1:0]  ref_col_hi,
  input  logic signed [rrs_pkg::PORT_BITS-1:0]  ref_row_hi,
  input  logic signed [rrs_pkg::PORT_BITS-1:0]  ref_sheet_hi,
  // result channel
  output logic                                 done,
  output logic signed [rrs_pkg::PORT_BITS-1:0]  new_col_lo,
  output logic signed [rrs_pkg::PORT_BITS-1:0]  new_row_lo,
  output logic signed [rrs_pkg::PORT_BITS-1:0]  new_sheet_lo,
  output logic signed [rrs_pkg::PORT_BITS-1:0]  new_col_hi,
  output logic signed [rrs_pkg::PORT_BITS-1:0]  new_row_hi,
  output logic signed [rrs_pkg::PORT_BITS-1:0]  new_sheet_hi,
  output logic                                 status,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [rrs_pkg::INDEX_BITS-1:0]        cfg_index,
  input  logic [rrs_pkg::PORT_BITS-1:0]         cfg_data
);
  import rrs_pkg::*;

  localparam int W = COORD_BITS;

  // Coordinates are held in offset form: the sign bit is inverted, so the
  // minimum coordinate is all zeros, the maximum all ones, and plain
  // unsigned compares give coordinate order.
  localparam logic [W-1:0] CSIGN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] to_off(input logic [PORT_BITS-1:0] v);
    return v[W-1:0] ^ CSIGN;
  endfunction

  function automatic logic [PORT_BITS-1:0] from_off(input logic [W-1:0] u);
    logic [W-1:0] v;
    v = u ^ CSIGN;
    return PORT_BITS'($signed(v));
  endfunction

  function automatic logic in_rng(input logic [W-1:0] lo, input logic [W-1:0] hi,
                                  input logic [W-1:0] rlo, input logic [W-1:0] rhi);
    return (lo >= rlo) && (hi <= rhi);
  endfunction

  // Configuration registers.
  mode_t        mode;
  logic [W-1:0] reg_col_lo, reg_col_hi;
  logic [W-1:0] reg_row_lo, reg_row_hi;
  logic [W-1:0] reg_sheet_lo, reg_sheet_hi;

  // Input register.
  logic                          in_valid;
  logic signed [DELTA_BITS-1:0]  d_col, d_row, d_sheet;
  logic [W-1:0]                  s_col_lo, s_col_hi;
  logic [W-1:0]                  s_row_lo, s_row_hi;
  logic [W-1:0]                  s_sheet_lo, s_sheet_hi;

  // Axis unit results.
  logic [W-1:0] n_col_lo, n_col_hi;
  logic [W-1:0] n_row_lo, n_row_hi;
  logic [W-1:0] n_sheet_lo, n_sheet_hi;
  logic         cut_col, cut_row, cut_sheet;
  axis_ctl_t    ctl_col, ctl_row, ctl_sheet;

  logic is_shift, is_move, inside_all, status_next;
  logic whole_col, whole_row, whole_sheet;
  logic orig_row_in, orig_sheet_in, orig_col_in, new_col_in, new_row_in;

  assign busy = rst;

  // Configuration writes. An index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SHIFT;
      reg_col_lo   <= CSIGN;
      reg_col_hi   <= CSIGN;
      reg_row_lo   <= CSIGN;
      reg_row_hi   <= CSIGN;
      reg_sheet_lo <= CSIGN;
      reg_sheet_hi <= CSIGN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode         <= mode_t'(cfg_data[1:0]);
        CFG_COL_LO:   reg_col_lo   <= to_off(cfg_data);
        CFG_COL_HI:   reg_col_hi   <= to_off(cfg_data);
        CFG_ROW_LO:   reg_row_lo   <= to_off(cfg_data);
        CFG_ROW_HI:   reg_row_hi   <= to_off(cfg_data);
        CFG_SHEET_LO: reg_sheet_lo <= to_off(cfg_data);
        CFG_SHEET_HI: reg_sheet_hi <= to_off(cfg_data);
        default: ;
      endcase
    end
  end

  // Input register: the transaction is converted to offset form on entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      d_col      <= shift_col;
      d_row      <= shift_row;
      d_sheet    <= shift_sheet;
      s_col_lo   <= to_off(ref_col_lo);
      s_col_hi   <= to_off(ref_col_hi);
      s_row_lo   <= to_off(ref_row_lo);
      s_row_hi   <= to_off(ref_row_hi);
      s_sheet_lo <= to_off(ref_sheet_lo);
      s_sheet_hi <= to_off(ref_sheet_hi);
    end
  end

  // Axis enables. In insert/delete mode the axes go in the order column,
  // row, sheet, and each test sees the bounds already moved by the earlier
  // axes. In move mode the whole range must lie inside the region as given.
  // A range that spans a whole axis never moves on that axis.
  assign is_shift      = (mode == MODE_SHIFT);
  assign is_move       = (mode == MODE_MOVE);
  assign whole_col     = (s_col_lo == '0) && (s_col_hi == '1);
  assign whole_row     = (s_row_lo == '0) && (s_row_hi == '1);
  assign whole_sheet   = (s_sheet_lo == '0) && (s_sheet_hi == '1);
  assign orig_col_in   = in_rng(s_col_lo, s_col_hi, reg_col_lo, reg_col_hi);
  assign orig_row_in   = in_rng(s_row_lo, s_row_hi, reg_row_lo, reg_row_hi);
  assign orig_sheet_in = in_rng(s_sheet_lo, s_sheet_hi, reg_sheet_lo, reg_sheet_hi);
  assign new_col_in    = in_rng(n_col_lo, n_col_hi, reg_col_lo, reg_col_hi);
  assign new_row_in    = in_rng(n_row_lo, n_row_hi, reg_row_lo, reg_row_hi);
  assign inside_all    = orig_col_in & orig_row_in & orig_sheet_in;

  always_comb begin
    ctl_col.clamp   = is_shift;
    ctl_row.clamp   = is_shift;
    ctl_sheet.clamp = is_shift;
    ctl_col.en   = (d_col != '0) && !whole_col &&
                   ((is_shift && orig_row_in && orig_sheet_in) ||
                    (is_move && inside_all));
    ctl_row.en   = (d_row != '0) && !whole_row &&
                   ((is_shift && new_col_in && orig_sheet_in) ||
                    (is_move && inside_all));
    ctl_sheet.en = (d_sheet != '0) && !whole_sheet &&
                   ((is_shift && new_col_in && new_row_in) ||
                    (is_move && inside_all));
  end

  rrs_axis #(.W(W)) u_axis_col (
    .lo     (s_col_lo),
    .hi     (s_col_hi),
    .start  (reg_col_lo),
    .delta  (d_col),
    .ctl    (ctl_col),
    .lo_new (n_col_lo),
    .hi_new (n_col_hi),
    .cut    (cut_col)
  );

  rrs_axis #(.W(W)) u_axis_row (
    .lo     (s_row_lo),
    .hi     (s_row_hi),
    .start  (reg_row_lo),
    .delta  (d_row),
    .ctl    (ctl_row),
    .lo_new (n_row_lo),
    .hi_new (n_row_hi),
    .cut    (cut_row)
  );

  rrs_axis #(.W(W)) u_axis_sheet (
    .lo     (s_sheet_lo),
    .hi     (s_sheet_hi),
    .start  (reg_sheet_lo),
    .delta  (d_sheet),
    .ctl    (ctl_sheet),
    .lo_new (n_sheet_lo),
    .hi_new (n_sheet_hi),
    .cut    (cut_sheet)
  );

  // Status is set when any bound moved or an overflow was cut or wrapped.
  assign status_next = cut_col | cut_row | cut_sheet |
                       (n_col_lo != s_col_lo) | (n_col_hi != s_col_hi) |
                       (n_row_lo != s_row_lo) | (n_row_hi != s_row_hi) |
                       (n_sheet_lo != s_sheet_lo) | (n_sheet_hi != s_sheet_hi);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      new_col_lo   <= from_off(n_col_lo);
      new_col_hi   <= from_off(n_col_hi);
      new_row_lo   <= from_off(n_row_lo);
      new_row_hi   <= from_off(n_row_hi);
      new_sheet_lo <= from_off(n_sheet_lo);
      new_sheet_hi <= from_off(n_sheet_hi);
      status       <= status_next;
    end
  end

  // Every accepted command produces exactly one result.
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy) |=> done)
    else $error("accepted transaction did not produce a result");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without a transaction in flight");

  // With no nonzero delta nothing can move or overflow.
  a_zero_delta_no_change: assert property (@(posedge clk) disable iff (rst)
    (in_valid && d_col == '0 && d_row == '0 && d_sheet == '0) |=> !status)
    else $error("status set for a transaction with all deltas zero");

  // The reorder mode and the unused mode code never change a range.
  a_idle_mode_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && $past(mode) != MODE_SHIFT && $past(mode) != MODE_MOVE) |-> !status)
    else $error("status set in a mode that makes no change");

endmodule

@@ hdl/rrs_axis.sv @@
// ----------------------------------------------------------------------------
// rrs_axis: shift of one axis of a reference range
// Moves both bounds of one axis by a signed delta, either with the
// insert/delete rule (bounds below the region start stay, high overflow
// clamps to the maximum) or with the move rule (wrap and flag overflow).
// Coordinates are in offset form, so unsigned order is coordinate order.
// ----------------------------------------------------------------------------
module rrs_axis #(
  parameter int W = 64
) (
  input  logic [W-1:0]                          lo,
  input  logic [W-1:0]                          hi,
  input  logic [W-1:0]                          start,
  input  logic signed [rrs_pkg::DELTA_BITS-1:0] delta,
  input  rrs_pkg::axis_ctl_t                    ctl,
  output logic [W-1:0]                          lo_new,
  output logic [W-1:0]                          hi_new,
  output logic                                  cut
);
  import rrs_pkg::*;

  // Sum width holds any coordinate plus any delta with a sign bit to spare.
  localparam int SW = ((W > DELTA_BITS) ? W : DELTA_BITS) + 2;

  logic signed [SW-1:0] dext;
  logic signed [SW-1:0] cmax;
  logic signed [SW-1:0] lo_sum;
  logic signed [SW-1:0] hi_sum;
  logic [W:0]           lo_res;
  logic [W:0]           hi_res;

  // Returns {cut, new value} for one bound.
  function automatic logic [W:0] bound_step(input logic [W-1:0] u,
                                            input logic signed [SW-1:0] sum,
                                            input axis_ctl_t c,
                                            input logic [W-1:0] st,
                                            input logic signed [SW-1:0] mx,
                                            input logic pos);
    logic over;
    logic under;
    logic [W:0] r;
    over  = sum > mx;
    under = sum < 0;
    r     = {1'b0, u};
    if (c.en) begin
      if (c.clamp) begin
        if (u >= st) begin
          if (pos && over) begin
            r = {1'b1, {W{1'b1}}};
          end else begin
            r = {1'b0, sum[W-1:0]};
          end
        end
      end else begin
        r = {over | under, sum[W-1:0]};
      end
    end
    return r;
  endfunction

  assign dext   = SW'(delta);
  assign cmax   = $signed({{(SW-W){1'b0}}, {W{1'b1}}});
  assign lo_sum = $signed({{(SW-W){1'b0}}, lo}) + dext;
  assign hi_sum = $signed({{(SW-W){1'b0}}, hi}) + dext;

  assign lo_res = bound_step(lo, lo_sum, ctl, start, cmax, ~delta[DELTA_BITS-1]);
  assign hi_res = bound_step(hi, hi_sum, ctl, start, cmax, ~delta[DELTA_BITS-1]);

  assign lo_new = lo_res[W-1:0];
  assign hi_new = hi_res[W-1:0];
  assign cut    = lo_res[W] | hi_res[W];

endmodule
